// File: sv/sosmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sosmc_pkg
// Shared types, codes and constants of the surface update core.
// ----------------------------------------------------------------------------
package sosmc_pkg;

	// default sizing
	localparam int COLUMNS_DEF      = 128;
	localparam int HEIGHT_LIMIT_DEF = 256;

	// fixed field widths
	localparam int OP_W    = 2;
	localparam int POS_W   = 7;
	localparam int FRAC_W  = 16;
	localparam int ACC_W   = 17;
	localparam int OUTH_W  = 8;
	localparam int SUM_W   = 15;
	localparam int NUM_ACC = 6;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [ACC_W-1:0] ACC_ALWAYS = ACC_W'(65536);

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD       = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE    = 2'd1;
	localparam logic [OP_W-1:0] OP_FORCE_ADD = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ADD_FALLING    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ADD_LEVEL      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ADD_RISING     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REMOVE_FALLING = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REMOVE_LEVEL   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_REMOVE_RISING  = 3'd5;

	typedef logic [NUM_ACC-1:0][ACC_W-1:0] acc_bank_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [POS_W-1:0]  position;
		logic [FRAC_W-1:0] random_fraction;
	} in_item_t;

	typedef struct packed {
		logic              accepted;
		logic [OUTH_W-1:0] new_height;
		logic [SUM_W-1:0]  particle_total;
	} out_item_t;

	// which column the height memory reads
	typedef enum logic [1:0] {
		RD_CENTER,
		RD_LEFT,
		RD_RIGHT
	} rd_sel_t;

	// which height register captures the read data
	typedef enum logic [1:0] {
		CAP_NONE,
		CAP_CENTER,
		CAP_LEFT,
		CAP_RIGHT
	} cap_sel_t;

	typedef struct packed {
		logic     clr_wr;
		logic     load_in;
		logic     rd_en;
		rd_sel_t  rd_sel;
		cap_sel_t cap_sel;
		logic     eval;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
	} dp_status_t;

endpackage : sosmc_pkg
`default_nettype wire

// File: sv/sosmc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sosmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sosmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : sosmc_ram
`default_nettype wire

// File: sv/sosmc_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sosmc_regs
// APB register bank holding the six acceptance fractions.
// ----------------------------------------------------------------------------
module sosmc_regs
	import sosmc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready,
	output      acc_bank_t          acc
);

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	acc_bank_t            acc_q;

	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign acc    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ACC; i++) begin
				acc_q[i] <= ACC_ALWAYS;
			end
		end else if (wr_en) begin
			unique case (idx)
				REG_ADD_FALLING:    acc_q[0] <= pwdata[ACC_W-1:0];
				REG_ADD_LEVEL:      acc_q[1] <= pwdata[ACC_W-1:0];
				REG_ADD_RISING:     acc_q[2] <= pwdata[ACC_W-1:0];
				REG_REMOVE_FALLING: acc_q[3] <= pwdata[ACC_W-1:0];
				REG_REMOVE_LEVEL:   acc_q[4] <= pwdata[ACC_W-1:0];
				REG_REMOVE_RISING:  acc_q[5] <= pwdata[ACC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ADD_FALLING:    prdata = PDATA_W'(acc_q[0]);
			REG_ADD_LEVEL:      prdata = PDATA_W'(acc_q[1]);
			REG_ADD_RISING:     prdata = PDATA_W'(acc_q[2]);
			REG_REMOVE_FALLING: prdata = PDATA_W'(acc_q[3]);
			REG_REMOVE_LEVEL:   prdata = PDATA_W'(acc_q[4]);
			REG_REMOVE_RISING:  prdata = PDATA_W'(acc_q[5]);
			default:            prdata = '0;
		endcase
	end

endmodule : sosmc_regs
`default_nettype wire

// File: sv/sosmc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sosmc_ctrl
// Sequencer: clearing pass, three height reads, evaluate, output handshake.
// ----------------------------------------------------------------------------
module sosmc_ctrl
	import sosmc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      dp_cmd_t    cmd,
	input  wire dp_status_t status
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_C,
		ST_RD_L,
		ST_RD_R,
		ST_CAP_R,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	// output register is free if empty or its beat leaves at this edge
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '{clr_wr: 1'b0, load_in: 1'b0, rd_en: 1'b0, rd_sel: RD_CENTER,
		        cap_sel: CAP_NONE, eval: 1'b0};
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE:  cmd.load_in = in_valid;
			ST_RD_C: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_CENTER;
			end
			ST_RD_L: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_LEFT;
				cmd.cap_sel = CAP_CENTER;
			end
			ST_RD_R: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_RIGHT;
				cmd.cap_sel = CAP_LEFT;
			end
			ST_CAP_R: cmd.cap_sel = CAP_RIGHT;
			ST_EVAL:  cmd.eval = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			// load a new beat on evaluate, else drop the one that leaves
			if (cmd.eval) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RD_C;
					end
				end
				ST_RD_C:  state_q <= ST_RD_L;
				ST_RD_L:  state_q <= ST_RD_R;
				ST_RD_R:  state_q <= ST_CAP_R;
				ST_CAP_R: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : sosmc_ctrl
`default_nettype wire

// File: sv/sosmc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sosmc_dp
// Datapath: item registers, height memory, acceptance decision, total count.
// ----------------------------------------------------------------------------
module sosmc_dp
	import sosmc_pkg::*;
#(
	parameter int COLUMNS      = COLUMNS_DEF,
	parameter int HEIGHT_LIMIT = HEIGHT_LIMIT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_item,
	input  wire acc_bank_t acc,
	input  wire dp_cmd_t   cmd,
	output      dp_status_t status,
	output      out_item_t out_item
);

	localparam int AW = $clog2(COLUMNS);
	localparam int HW = $clog2(HEIGHT_LIMIT);
	localparam logic [AW-1:0] LAST_COL = AW'(COLUMNS - 1);
	localparam logic [HW-1:0] TOP_H    = HW'(HEIGHT_LIMIT - 1);

	logic [OP_W-1:0]   op_q;
	logic [AW-1:0]     pos_q;
	logic [FRAC_W-1:0] rnd_q;
	logic [AW-1:0]     clr_q;
	logic [HW-1:0]     h_q, hl_q, hr_q;
	logic [SUM_W-1:0]  sum_q;
	out_item_t         out_q;

	logic [POS_W-1:0]  pos_red;
	logic [AW-1:0]     left_col, right_col, raddr, waddr;
	logic [HW-1:0]     rdata, wdata, h2, h_new;
	logic              adding, removing, in_range, accept;
	logic [1:0]        n_toward;
	logic [ACC_W-1:0]  acc_sel;
	logic [SUM_W-1:0]  sum_next;

	// reduce the position modulo the ring size by restoring subtraction
	always_comb begin
		pos_red = in_item.position;
		for (int k = POS_W - 1; k >= 0; k--) begin
			if (32'(pos_red) >= (32'(COLUMNS) << k)) begin
				pos_red = pos_red - POS_W'(32'(COLUMNS) << k);
			end
		end
	end

	assign left_col  = (pos_q == '0) ? LAST_COL : pos_q - AW'(1);
	assign right_col = (pos_q == LAST_COL) ? '0 : pos_q + AW'(1);

	always_comb begin
		case (cmd.rd_sel)
			RD_LEFT:  raddr = left_col;
			RD_RIGHT: raddr = right_col;
			default:  raddr = pos_q;
		endcase
	end

	assign status.clr_last = (clr_q == LAST_COL);

	// decision
	assign adding   = (op_q == OP_ADD) || (op_q == OP_FORCE_ADD);
	assign removing = (op_q == OP_REMOVE);
	assign in_range = adding ? (h_q != TOP_H) : (removing && (h_q != '0));
	assign h2       = adding ? h_q + HW'(1) : h_q - HW'(1);

	// a neighbor on the side the column moves toward lowers the energy by one
	always_comb begin
		if (adding) begin
			n_toward = {1'b0, hl_q > h_q} + {1'b0, hr_q > h_q};
		end else begin
			n_toward = {1'b0, hl_q < h_q} + {1'b0, hr_q < h_q};
		end
	end

	always_comb begin
		case ({removing, n_toward})
			3'b010:  acc_sel = acc[REG_ADD_FALLING];
			3'b001:  acc_sel = acc[REG_ADD_LEVEL];
			3'b000:  acc_sel = acc[REG_ADD_RISING];
			3'b110:  acc_sel = acc[REG_REMOVE_FALLING];
			3'b101:  acc_sel = acc[REG_REMOVE_LEVEL];
			3'b100:  acc_sel = acc[REG_REMOVE_RISING];
			default: acc_sel = '0;
		endcase
	end

	always_comb begin
		if (!in_range) begin
			accept = 1'b0;
		end else if (op_q == OP_FORCE_ADD) begin
			accept = 1'b1;
		end else begin
			accept = {1'b0, rnd_q} < acc_sel;
		end
	end

	assign h_new    = accept ? h2 : h_q;
	assign sum_next = !accept ? sum_q : (adding ? sum_q + SUM_W'(1) : sum_q - SUM_W'(1));

	assign waddr = cmd.clr_wr ? clr_q : pos_q;
	assign wdata = cmd.clr_wr ? '0 : h2;

	sosmc_ram #(
		.WIDTH(HW),
		.DEPTH(COLUMNS)
	) u_heights (
		.clk  (clk),
		.we   (cmd.clr_wr | (cmd.eval & accept)),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= in_item.operation;
			pos_q <= AW'(pos_red);
			rnd_q <= in_item.random_fraction;
		end
		case (cmd.cap_sel)
			CAP_CENTER: h_q  <= rdata;
			CAP_LEFT:   hl_q <= rdata;
			CAP_RIGHT:  hr_q <= rdata;
			default: ;
		endcase
		if (cmd.eval) begin
			out_q.accepted       <= accept;
			out_q.new_height     <= OUTH_W'(h_new);
			out_q.particle_total <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.eval) begin
				sum_q <= sum_next;
			end
		end
	end

	assign out_item = out_q;

endmodule : sosmc_dp
`default_nettype wire

// File: sv/sos_surface_monte_carlo_update_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sos_surface_monte_carlo_update_core
// Metropolis add/remove update of a solid-on-solid surface on a ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes one move per beat:
//   operation, position and a 0.16 random fraction. Output channel
//   (out_valid / out_stall / out_item) returns one beat per move: accepted,
//   new column height and the particle total.
//   Sequence: after the accept step a move does three reads through the
//   single read port of the height memory, one capture step and one
//   evaluate/write step. The next move is taken while the previous result
//   waits.
//   Reset: arst_n clears the controller, the total and the acceptance
//   registers (all read 65536, always accept); then a clearing pass writes
//   zero to every column with in_stall held high. Stall: while out_stall
//   holds a result beat, the next move still runs up to its evaluate step
//   and waits there; nothing is dropped. The user must write acceptance
//   fractions over APB only while the core is idle; the core never checks.
// ----------------------------------------------------------------------------
module sos_surface_monte_carlo_update_core
	import sosmc_pkg::*;
#(
	parameter int COLUMNS      = COLUMNS_DEF,
	parameter int HEIGHT_LIMIT = HEIGHT_LIMIT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire in_item_t           in_item,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      out_item_t          out_item,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready
);

	acc_bank_t  acc;
	dp_cmd_t    cmd;
	dp_status_t status;

	// acceptance fraction registers
	sosmc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.acc    (acc)
	);

	// sequencer: clear, read three columns, evaluate, hand off the beat
	sosmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.status   (status)
	);

	// heights, decision and particle total
	sosmc_dp #(
		.COLUMNS     (COLUMNS),
		.HEIGHT_LIMIT(HEIGHT_LIMIT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.acc     (acc),
		.cmd     (cmd),
		.status  (status),
		.out_item(out_item)
	);

endmodule : sos_surface_monte_carlo_update_core
`default_nettype wire
